FILE: rtl/olt_pkg.sv
// Shared types, codes and defaults for the ordered list table.
package olt_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;
  // A dump reads out at most this many entries.
  localparam int RESULT_LIMIT   = 32;
  // Width used when counts are compared against the result limit.
  localparam int CMP_W          = 8;

  localparam int KIND_W   = 3;
  localparam int FIELD_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND     = 3'd0,
    KIND_DEL_TAIL   = 3'd1,
    KIND_DEL_HEAD   = 3'd2,
    KIND_DEL_POS    = 3'd3,
    KIND_DEL_KEY    = 3'd4,
    KIND_DUMP       = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_BAD_POS   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT,
    CELL_ROTATE,
    CELL_MATCH
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DUMP
  } state_t;

endpackage

FILE: rtl/ordered_list_table.sv
// Top level of the ordered list table: cell chain and its sequencer.
//
// The block keeps an ordered list of up to CAPACITY signed entries in a chain of
// cells, one entry per cell, with the head in the first cell. Each input word on
// the in_ channel is one operation; every operation gives one result word on the
// out_ channel, except a dump of a non-empty list, which gives one word per entry
// (at most 32), with out_last set on the final one.
// Append and the tail, head and position deletes finish in the cycle the word is
// taken: append writes the cell at the count, a head or position delete has the
// cells from the gap on copy their right-hand neighbours in one step, and the
// result is offered on the next cycle. A key delete first latches a compare in
// every cell, then walks the match flags one cell per cycle. A dump rotates the
// whole chain round once, presenting the head cell each step, and leaves the
// order as it was. One operation is handled at a time; a new input word is taken
// once the sequencer is idle and the result register is empty or being emptied.
// If the receiver stalls, the result register holds its word and the key walk or
// dump rotation pauses until the word is taken; nothing is dropped.
// Reset empties the list and the result register; cell contents are not cleared,
// since only cells below the count are ever read.
module ordered_list_table #(
  parameter int CAPACITY   = olt_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = olt_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [olt_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [olt_pkg::FIELD_W-1:0]  in_value,
  input  logic [olt_pkg::POS_W-1:0]           in_position,
  input  logic signed [olt_pkg::FIELD_W-1:0]  in_key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [olt_pkg::STATUS_W-1:0]        out_status,
  output logic signed [olt_pkg::FIELD_W-1:0]  out_entry,
  output logic                                out_entry_valid,
  output logic [olt_pkg::COUNT_W-1:0]         out_entry_count,
  output logic                                out_last
);
  import olt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]      scan_r, scan_nxt;
  logic [IDX_W-1:0]      rot_r, rot_nxt;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [FIELD_W-1:0]    out_entry_r;
  logic                  out_entry_valid_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_last_r;

  logic                  res_load;
  status_t               res_status;
  logic [FIELD_W-1:0]    res_entry;
  logic                  res_entry_valid;
  logic                  res_last;

  cell_op_t              cell_op;
  logic [IDX_W-1:0]      cell_idx;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] key_fit;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   match_vec;

  logic                  out_free;
  logic                  in_fire;
  logic [CMP_W-1:0]      dump_len;
  logic                  emit;
  kind_t                 kind;

  // Values and keys are cut or sign-extended to the stored width.
  assign wdata   = DATA_WIDTH'(in_value);
  assign key_fit = DATA_WIDTH'(in_key);

  // The chain: each cell sees its right-hand neighbour, the last one sees the
  // head, which closes the ring used by the dump rotation.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    olt_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX_W     (IDX_W),
      .INDEX     (g)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op),
      .idx      (cell_idx),
      .wdata    (wdata),
      .key      (key_fit),
      .next_data(cell_data[(g + 1) % CAPACITY]),
      .data     (cell_data[g]),
      .match    (match_vec[g])
    );
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign kind     = kind_t'(in_kind);

  // A dump reads out the smaller of the count and the result limit.
  assign dump_len = (CMP_W'(count_r) > CMP_W'(RESULT_LIMIT)) ? CMP_W'(RESULT_LIMIT)
                                                             : CMP_W'(count_r);
  assign emit     = CMP_W'(rot_r) < dump_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      rot_r   <= rot_nxt;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Result register payload: loaded together with the valid flag.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r      <= res_status;
      out_entry_r       <= res_entry;
      out_entry_valid_r <= res_entry_valid;
      out_count_r       <= COUNT_W'(count_nxt);
      out_last_r        <= res_last;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    scan_nxt        = scan_r;
    rot_nxt         = rot_r;
    cell_op         = CELL_HOLD;
    cell_idx        = '0;
    res_load        = 1'b0;
    res_status      = STAT_OK;
    res_entry       = '0;
    res_entry_valid = 1'b0;
    res_last        = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          unique case (kind)
            KIND_APPEND: begin
              if (CMP_W'(count_r) >= CMP_W'(CAPACITY)) begin
                res_status = STAT_FULL;
              end else begin
                cell_op   = CELL_WRITE;
                cell_idx  = IDX_W'(count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_DEL_TAIL: begin
              if (count_r == '0) res_status = STAT_EMPTY;
              else count_nxt = count_r - CW'(1);
            end
            KIND_DEL_HEAD: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                cell_op   = CELL_SHIFT;
                cell_idx  = '0;
                count_nxt = count_r - CW'(1);
              end
            end
            KIND_DEL_POS: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else if (in_position == '0 ||
                           CMP_W'(in_position) > CMP_W'(count_r)) begin
                res_status = STAT_BAD_POS;
              end else begin
                cell_op   = CELL_SHIFT;
                cell_idx  = IDX_W'(in_position - POS_W'(1));
                count_nxt = count_r - CW'(1);
              end
            end
            KIND_DEL_KEY: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                // Every cell latches its compare; the walk follows.
                res_load  = 1'b0;
                cell_op   = CELL_MATCH;
                scan_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            KIND_DUMP: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_load  = 1'b0;
                rot_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (out_free) begin
          if (match_vec[scan_r]) begin
            cell_op   = CELL_SHIFT;
            cell_idx  = scan_r;
            count_nxt = count_r - CW'(1);
            res_load  = 1'b1;
            state_nxt = S_IDLE;
          end else if (scan_r == IDX_W'(count_r - CW'(1))) begin
            res_load   = 1'b1;
            res_status = STAT_NOT_FOUND;
            state_nxt  = S_IDLE;
          end else begin
            scan_nxt = scan_r + IDX_W'(1);
          end
        end
      end

      S_DUMP: begin
        // The ring turns once in full; the head is read out while it is in use.
        if (!emit || out_free) begin
          cell_op = CELL_ROTATE;
          rot_nxt = rot_r + IDX_W'(1);
          if (emit) begin
            res_load        = 1'b1;
            res_entry       = FIELD_W'(signed'(cell_data[0]));
            res_entry_valid = 1'b1;
            res_last        = (CMP_W'(rot_r) + CMP_W'(1)) == dump_len;
          end
          if (rot_r == IDX_W'(CAPACITY - 1)) begin
            rot_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry       = out_entry_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

FILE: rtl/olt_cell.sv
// One storage cell of the list chain: holds an entry and its key match flag.
module olt_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  olt_pkg::cell_op_t      op,
  input  logic [IDX_W-1:0]       idx,
  input  logic [DATA_WIDTH-1:0]  wdata,
  input  logic [DATA_WIDTH-1:0]  key,
  input  logic [DATA_WIDTH-1:0]  next_data,
  output logic [DATA_WIDTH-1:0]  data,
  output logic                   match
);
  import olt_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic                  match_r;

  // The cell writes, takes its right-hand neighbour's entry or latches a key match.
  always_ff @(posedge clk) begin
    unique case (op)
      CELL_WRITE: begin
        if (idx == IDX_W'(INDEX)) data_r <= wdata;
      end
      CELL_SHIFT: begin
        if (idx <= IDX_W'(INDEX)) data_r <= next_data;
      end
      CELL_ROTATE: data_r <= next_data;
      CELL_MATCH:  match_r <= (data_r == key);
      default: ;
    endcase
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for the ordered list table: directed table, then random op sequences.
`timescale 1ns / 1ps

module tb_top;
  import olt_pkg::*;

  // The bench runs the block at its default size, so the list holds up to
  // 32 entries and a dump of a full list gives the longest burst of words.
  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int PHASE_ITEMS = 56;
  localparam int CYCLE_LIMIT = 400000;
  // A dump rotates the whole chain once, and that is the longest the block
  // stays busy; the settling time at the end leaves ample room for it.
  localparam int SETTLE_CYCLES = 2 * CAPACITY;
  localparam int REPORT_LIMIT  = 10;

  // Kinds that the block ignores; they still return one plain word.
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  // How the random stream chooses its next operation.
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_DUMP, MIX_ANY} op_mix_t;

  // One result word, field by field.
  typedef struct packed {
    status_t                   status;
    logic signed [FIELD_W-1:0] entry;
    logic                      entry_valid;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } list_word_t;

  // One row of the directed table. Where the result is a single plain word
  // (error codes and counts) it is typed in here; the dumps of a non-empty
  // list are checked against the predictor.
  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic signed [FIELD_W-1:0] key;
    bit                        typed;
    status_t                   status;
    logic [COUNT_W-1:0]        count;
  } table_row_t;

  localparam int TABLE_ROWS = 22;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [KIND_W-1:0]         in_kind;
  logic signed [FIELD_W-1:0] in_value;
  logic [POS_W-1:0]          in_position;
  logic signed [FIELD_W-1:0] in_key;
  logic                      out_valid;
  logic                      out_ready;
  logic [STATUS_W-1:0]       out_status;
  logic signed [FIELD_W-1:0] out_entry;
  logic                      out_entry_valid;
  logic [COUNT_W-1:0]        out_entry_count;
  logic                      out_last;

  // Mirror of the list contents, head first, and the words still owed.
  logic signed [FIELD_W-1:0] list_mirror[$];
  list_word_t                owed_words[$];
  list_word_t                fresh_words[$];

  table_row_t directed_rows[TABLE_ROWS];

  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int mismatch_count;
  int ops_sent;
  int words_checked;
  int dump_words;
  int status_seen[5];

  ordered_list_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_position     (in_position),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry       (out_entry),
    .out_entry_valid (out_entry_valid),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Works out the words that one accepted operation gives and updates the
  // mirror. The words land in fresh_words so that the caller may replace
  // them with a typed-in expectation.
  function automatic void predict_list_op(input logic [KIND_W-1:0] kind,
                                          input logic signed [FIELD_W-1:0] value,
                                          input logic [POS_W-1:0] position,
                                          input logic signed [FIELD_W-1:0] key);
    status_t st;
    int      n;
    int      hit;
    st  = STAT_OK;
    hit = -1;
    fresh_words.delete();
    case (kind)
      KIND_APPEND: begin
        if (list_mirror.size() >= CAPACITY) st = STAT_FULL;
        else list_mirror.push_back(value);
      end
      KIND_DEL_TAIL: begin
        if (list_mirror.size() == 0) st = STAT_EMPTY;
        else list_mirror.delete(list_mirror.size() - 1);
      end
      KIND_DEL_HEAD: begin
        if (list_mirror.size() == 0) st = STAT_EMPTY;
        else list_mirror.delete(0);
      end
      KIND_DEL_POS: begin
        if (list_mirror.size() == 0) st = STAT_EMPTY;
        else if (position == 0 || int'(position) > list_mirror.size()) st = STAT_BAD_POS;
        else list_mirror.delete(int'(position) - 1);
      end
      KIND_DEL_KEY: begin
        if (list_mirror.size() == 0) begin
          st = STAT_EMPTY;
        end else begin
          for (int i = 0; i < list_mirror.size() && hit < 0; i++)
            if (list_mirror[i] == key) hit = i;
          if (hit < 0) st = STAT_NOT_FOUND;
          else list_mirror.delete(hit);
        end
      end
      KIND_DUMP: begin
        if (list_mirror.size() == 0) begin
          st = STAT_EMPTY;
        end else begin
          // A dump never reads out more than the result limit allows.
          n = (list_mirror.size() > RESULT_LIMIT) ? RESULT_LIMIT : list_mirror.size();
          for (int i = 0; i < n; i++)
            fresh_words.push_back('{STAT_OK, list_mirror[i], 1'b1,
                                    COUNT_W'(list_mirror.size()), (i == n - 1)});
        end
      end
      default: ;
    endcase
    if (fresh_words.size() == 0)
      fresh_words.push_back('{st, '0, 1'b0, COUNT_W'(list_mirror.size()), 1'b1});
    if (kind <= KIND_DUMP) status_seen[st]++;
  endfunction

  // Offers one word on the input channel, after a random idle spell, and
  // books its expected results at the edge where it is accepted.
  task automatic send_word(input logic [KIND_W-1:0] kind,
                           input logic signed [FIELD_W-1:0] value,
                           input logic [POS_W-1:0] position,
                           input logic signed [FIELD_W-1:0] key,
                           input bit typed,
                           input status_t typed_status,
                           input logic [COUNT_W-1:0] typed_count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_kind     = kind;
    in_value    = value;
    in_position = position;
    in_key      = key;
    do @(posedge clk); while (!in_ready);
    predict_list_op(kind, value, position, key);
    if (typed) owed_words.push_back('{typed_status, '0, 1'b0, typed_count, 1'b1});
    else foreach (fresh_words[i]) owed_words.push_back(fresh_words[i]);
    if (kind <= KIND_DUMP) ops_sent++;
    @(negedge clk);
  endtask

  // Holds the input side quiet until every owed word has come back.
  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (owed_words.size() != 0) @(negedge clk);
  endtask

  // Values lean towards the extremes and a small pool, so that duplicates
  // turn up and a key delete has to pick the first of several matches.
  function automatic logic signed [FIELD_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 32'sh8000_0000;
    if (r < 8) return 32'sh7fff_ffff;
    if (r < 11) return '0;
    if (r < 14) return -32'sd1;
    if (r < 40) return FIELD_W'($urandom_range(3)) - 32'sd2;
    return $urandom;
  endfunction

  // Builds one random operation of the chosen mix and sends it. Fields that
  // the operation does not use carry random rubbish.
  task automatic random_op(input op_mix_t mix);
    logic [KIND_W-1:0]         kind;
    logic signed [FIELD_W-1:0] value;
    logic signed [FIELD_W-1:0] key;
    logic [POS_W-1:0]          position;
    int                        n;
    int                        r;
    n        = list_mirror.size();
    value    = pick_value();
    key      = $urandom;
    position = POS_W'($urandom_range(63));
    r        = $urandom_range(99);
    case (mix)
      MIX_GROW:   kind = KIND_APPEND;
      MIX_DUMP:   kind = KIND_DUMP;
      MIX_SHRINK: begin
        if (r < 20) kind = KIND_DEL_TAIL;
        else if (r < 40) kind = KIND_DEL_HEAD;
        else if (r < 70) kind = KIND_DEL_POS;
        else kind = KIND_DEL_KEY;
      end
      default: begin
        if (r < 30) kind = KIND_APPEND;
        else if (r < 40) kind = KIND_DEL_TAIL;
        else if (r < 50) kind = KIND_DEL_HEAD;
        else if (r < 65) kind = KIND_DEL_POS;
        else if (r < 83) kind = KIND_DEL_KEY;
        else if (r < 96) kind = KIND_DUMP;
        else kind = (r < 98) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
      end
    endcase
    // Most positions and keys hit the list; the rest probe the error paths.
    if (kind == KIND_DEL_POS && n > 0 && $urandom_range(9) < 8)
      position = POS_W'($urandom_range(n, 1));
    if (kind == KIND_DEL_KEY)
      key = (n > 0 && $urandom_range(9) < 7) ? list_mirror[$urandom_range(n - 1)]
                                             : pick_value();
    send_word(kind, value, position, key, 1'b0, STAT_OK, '0);
  endtask

  // The receiver stalls at random, with the odds set per phase.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result word is matched against the oldest one owed.
  always @(posedge clk) begin
    list_word_t got;
    list_word_t want;
    got = '{status_t'(out_status), out_entry, out_entry_valid, out_entry_count, out_last};
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (out_entry_valid) dump_words++;
      if (owed_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected word status=%0d entry=%h valid=%0b count=%0d last=%0b",
                   $realtime, got.status, got.entry, got.entry_valid, got.count, got.last);
      end else begin
        want = owed_words.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: word mismatch", $realtime);
            $display("  expected status=%0d entry=%h valid=%0b count=%0d last=%0b",
                     want.status, want.entry, want.entry_valid, want.count, want.last);
            $display("  actual   status=%0d entry=%h valid=%0b count=%0d last=%0b",
                     got.status, got.entry, got.entry_valid, got.count, got.last);
          end
        end
      end
    end
  end

  // Guard against a hang: the limit sits far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words owed", cycle_count, owed_words.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int phase_ops;
    int r;
    in_valid       = 1'b0;
    in_kind        = KIND_APPEND;
    in_value       = '0;
    in_position    = '0;
    in_key         = '0;
    out_ready      = 1'b0;
    rst_n          = 1'b0;
    send_idle_pct  = 35;
    recv_idle_pct  = 74;
    cycle_count    = 0;
    mismatch_count = 0;
    ops_sent       = 0;
    words_checked  = 0;
    dump_words     = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Directed part: every delete on an empty list, a lone entry removed
    // from the tail, the signed extremes, positions of zero and beyond the
    // count, a key held by the head, a key that is absent, deleting the
    // first position, the ignored kinds, and dumps of empty and short lists.
    directed_rows = '{
      '{KIND_DUMP,      32'sd0,           6'd0,  32'sd0,           1'b1, STAT_EMPTY,     6'd0},
      '{KIND_DEL_TAIL,  32'sd0,           6'd0,  32'sd0,           1'b1, STAT_EMPTY,     6'd0},
      '{KIND_DEL_HEAD,  32'sd0,           6'd0,  32'sd0,           1'b1, STAT_EMPTY,     6'd0},
      '{KIND_DEL_POS,   32'sd0,           6'd1,  32'sd0,           1'b1, STAT_EMPTY,     6'd0},
      '{KIND_DEL_KEY,   32'sd0,           6'd0,  32'sd0,           1'b1, STAT_EMPTY,     6'd0},
      '{KIND_APPEND,    32'sh7fff_ffff,   6'd0,  32'sd0,           1'b1, STAT_OK,        6'd1},
      '{KIND_DEL_TAIL,  32'sd0,           6'd0,  32'sd0,           1'b1, STAT_OK,        6'd0},
      '{KIND_APPEND,    32'sh8000_0000,   6'd0,  32'sd0,           1'b1, STAT_OK,        6'd1},
      '{KIND_APPEND,    32'sd0,           6'd63, -32'sd1,          1'b1, STAT_OK,        6'd2},
      '{KIND_APPEND,    -32'sd1,          6'd0,  32'sd0,           1'b1, STAT_OK,        6'd3},
      '{KIND_APPEND,    32'sh7fff_ffff,   6'd0,  32'sd0,           1'b1, STAT_OK,        6'd4},
      '{KIND_DEL_POS,   32'sd0,           6'd0,  32'sd0,           1'b1, STAT_BAD_POS,   6'd4},
      '{KIND_DEL_POS,   32'sd0,           6'd5,  32'sd0,           1'b1, STAT_BAD_POS,   6'd4},
      '{KIND_DEL_POS,   32'sd0,           6'd63, 32'sd0,           1'b1, STAT_BAD_POS,   6'd4},
      '{KIND_DUMP,      -32'sd1,          6'd63, -32'sd1,          1'b0, STAT_OK,        6'd0},
      '{KIND_DEL_KEY,   32'sd0,           6'd0,  32'sh8000_0000,   1'b1, STAT_OK,        6'd3},
      '{KIND_DEL_KEY,   32'sd0,           6'd0,  32'sd12345,       1'b1, STAT_NOT_FOUND, 6'd3},
      '{KIND_DEL_POS,   32'sd0,           6'd1,  32'sd0,           1'b1, STAT_OK,        6'd2},
      '{KIND_DEL_HEAD,  32'sd0,           6'd0,  32'sd0,           1'b1, STAT_OK,        6'd1},
      '{KIND_UNUSED_LO, 32'sh7fff_ffff,   6'd1,  32'sh7fff_ffff,   1'b1, STAT_OK,        6'd1},
      '{KIND_UNUSED_HI, -32'sd1,          6'd63, -32'sd1,          1'b1, STAT_OK,        6'd1},
      '{KIND_DUMP,      32'sd0,           6'd0,  32'sd0,           1'b0, STAT_OK,        6'd0}
    };

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].position,
                directed_rows[i].key, directed_rows[i].typed, directed_rows[i].status,
                directed_rows[i].count);
    wait_for_drain();

    // Random part in three phases: a slow sender facing a stalling receiver,
    // then the reverse, then both sides flat out. Each phase opens by filling
    // the list, pushing once more against the full list and dumping all of
    // it, then carries on with grow, shrink and mixed runs.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 35 : 0;
      phase_ops     = ops_sent;
      while (list_mirror.size() < CAPACITY) random_op(MIX_GROW);
      random_op(MIX_GROW);
      random_op(MIX_DUMP);
      while (ops_sent - phase_ops < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 25) begin
          repeat ($urandom_range(8, 3)) random_op(MIX_GROW);
          random_op(MIX_DUMP);
        end else if (r < 40) begin
          // Run the list dry, then keep deleting on the empty list.
          while (list_mirror.size() > 0) random_op(MIX_SHRINK);
          repeat ($urandom_range(2, 1)) random_op(MIX_SHRINK);
          random_op(MIX_DUMP);
        end else if (r < 55) begin
          repeat ($urandom_range(6, 2)) random_op(MIX_SHRINK);
        end else begin
          repeat ($urandom_range(10, 4)) random_op(MIX_ANY);
        end
      end
      // The sender holds off here until the block has caught up entirely.
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d operations and %0d result words, %0d of them dumped entries",
             ops_sent, words_checked, dump_words);
    $display("status counts: ok %0d, full %0d, empty %0d, bad position %0d, key missing %0d",
             status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_EMPTY],
             status_seen[STAT_BAD_POS], status_seen[STAT_NOT_FOUND]);
    if (mismatch_count == 0 && owed_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/olt_pkg.sv
rtl/olt_cell.sv
rtl/ordered_list_table.sv
sim/tb_top.sv
